FILE: hw/rtl/lav_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_pkg
// Shared types and row codes of the look-at view matrix unit.
// ----------------------------------------------------------------------------
package lav_pkg;

  typedef logic [1:0] row_idx_t;

  localparam row_idx_t ROW_RIGHT = 2'd0;
  localparam row_idx_t ROW_UP    = 2'd1;
  localparam row_idx_t ROW_FWD   = 2'd2;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] aim_x;
    logic signed [31:0] aim_y;
    logic signed [31:0] aim_z;
    logic signed [31:0] sky_x;
    logic signed [31:0] sky_y;
    logic signed [31:0] sky_z;
  } pose_t;

  typedef struct packed {
    row_idx_t           row_index;
    logic signed [31:0] col0;
    logic signed [31:0] col1;
    logic signed [31:0] col2;
    logic signed [31:0] col3;
    logic               last_row;
    logic               degenerate;
  } row_t;

  typedef struct packed {
    logic [31:0] col0;
    logic [31:0] col1;
    logic [31:0] col2;
    logic [31:0] col3;
  } mrow_t;

endpackage

FILE: hw/rtl/lav_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_if
// Valid/ready channels for pose requests and matrix row results.
// ----------------------------------------------------------------------------
interface lav_pose_if;
  logic           valid;
  logic           ready;
  lav_pkg::pose_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface lav_row_if;
  logic          valid;
  logic          ready;
  lav_pkg::row_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hw/rtl/lav_unitize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_unitize
// Pipelined 3-vector normalizer: scale to bit 29, sum of squares, one root
// bit per stage, one quotient bit per stage on three lanes.
// ----------------------------------------------------------------------------
module lav_unitize #(
  parameter int IW = 33,
  parameter int FB = 16,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][IW-1:0]   in_v,
  input  logic [SW-1:0]        in_side,
  output logic                 out_valid,
  output logic [2:0][FB+1:0]   out_n,
  output logic                 out_ok,
  output logic [SW-1:0]        out_side
);

  localparam int LW  = $clog2(IW);
  localparam int MW  = 30;
  localparam int TW  = IW + MW;
  localparam int SQN = 32;
  localparam int QW  = FB + 1;
  localparam int NW  = FB + 2;
  localparam int XW  = 64;
  localparam int LNW = 32;

  logic [2:0][IW-1:0] mg_in;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg_in[i] = in_v[i][IW-1] ? (~in_v[i] + 1'b1) : in_v[i];
    end
  end

  // magnitudes
  logic               a_vld;
  logic [SW-1:0]      a_side;
  logic [2:0]         a_sg;
  logic [2:0][IW-1:0] a_mg;
  logic [IW-1:0]      a_or;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= in_valid;
    if (en) begin
      a_side <= in_side;
      for (int i = 0; i < 3; i++) a_sg[i] <= in_v[i][IW-1];
      a_mg <= mg_in;
      a_or <= mg_in[0] | mg_in[1] | mg_in[2];
    end
  end

  // leading one position
  logic [LW-1:0]      b_pn;
  logic               b_vld;
  logic [SW-1:0]      b_side;
  logic [2:0]         b_sg;
  logic [2:0][IW-1:0] b_mg;
  logic [LW-1:0]      b_p;
  logic               b_ok;

  always_comb begin
    b_pn = '0;
    for (int i = 0; i < IW; i++) begin
      if (a_or[i]) b_pn = LW'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
    if (en) begin
      b_side <= a_side;
      b_sg   <= a_sg;
      b_mg   <= a_mg;
      b_p    <= b_pn;
      b_ok   <= |a_or;
    end
  end

  // scale so the top bit sits at bit 29
  logic [2:0][TW-1:0] c_sh;
  logic               c_vld;
  logic [SW-1:0]      c_side;
  logic [2:0]         c_sg;
  logic [2:0][MW-1:0] c_m;
  logic               c_ok;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (b_p > LW'(MW - 1)) c_sh[i] = TW'(b_mg[i]) >> (b_p - LW'(MW - 1));
      else c_sh[i] = TW'(b_mg[i]) << (LW'(MW - 1) - b_p);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (en) c_vld <= b_vld;
    if (en) begin
      c_side <= b_side;
      c_sg   <= b_sg;
      c_ok   <= b_ok;
      for (int i = 0; i < 3; i++) c_m[i] <= c_sh[i][MW-1:0];
    end
  end

  // squares
  logic                 d_vld;
  logic [SW-1:0]        d_side;
  logic [2:0]           d_sg;
  logic [2:0][MW-1:0]   d_m;
  logic [2:0][2*MW-1:0] d_sq;
  logic                 d_ok;

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else if (en) d_vld <= c_vld;
    if (en) begin
      d_side <= c_side;
      d_sg   <= c_sg;
      d_ok   <= c_ok;
      d_m    <= c_m;
      for (int i = 0; i < 3; i++) d_sq[i] <= c_m[i] * c_m[i];
    end
  end

  // square root, one result bit per stage
  logic               q_vld  [SQN+1];
  logic [SW-1:0]      q_side [SQN+1];
  logic [2:0]         q_sg   [SQN+1];
  logic [2:0][MW-1:0] q_m    [SQN+1];
  logic               q_ok   [SQN+1];
  logic [XW-1:0]      q_x    [SQN+1];
  logic [XW-1:0]      q_r    [SQN+1];

  always_ff @(posedge clk) begin
    if (rst) q_vld[0] <= 1'b0;
    else if (en) q_vld[0] <= d_vld;
    if (en) begin
      q_side[0] <= d_side;
      q_sg[0]   <= d_sg;
      q_m[0]    <= d_m;
      q_ok[0]   <= d_ok;
      q_x[0]    <= XW'(d_sq[0]) + XW'(d_sq[1]) + XW'(d_sq[2]);
      q_r[0]    <= '0;
    end
  end

  for (genvar k = 1; k <= SQN; k++) begin : g_sqrt
    localparam logic [XW-1:0] STEP_BIT = XW'(1) << (2 * (SQN - k));
    logic [XW-1:0] trial;

    assign trial = q_r[k-1] + STEP_BIT;

    always_ff @(posedge clk) begin
      if (rst) q_vld[k] <= 1'b0;
      else if (en) q_vld[k] <= q_vld[k-1];
      if (en) begin
        q_side[k] <= q_side[k-1];
        q_sg[k]   <= q_sg[k-1];
        q_m[k]    <= q_m[k-1];
        q_ok[k]   <= q_ok[k-1];
        if (q_x[k-1] >= trial) begin
          q_x[k] <= q_x[k-1] - trial;
          q_r[k] <= (q_r[k-1] >> 1) + STEP_BIT;
        end else begin
          q_x[k] <= q_x[k-1];
          q_r[k] <= q_r[k-1] >> 1;
        end
      end
    end
  end

  // restoring division, one quotient bit per stage on each lane
  logic               v_vld  [QW+1];
  logic [SW-1:0]      v_side [QW+1];
  logic [2:0]         v_sg   [QW+1];
  logic               v_ok   [QW+1];
  logic [LNW-1:0]     v_len  [QW+1];
  logic [2:0][XW-1:0] v_rem  [QW+1];
  logic [2:0][QW-1:0] v_q    [QW+1];

  always_ff @(posedge clk) begin
    if (rst) v_vld[0] <= 1'b0;
    else if (en) v_vld[0] <= q_vld[SQN];
    if (en) begin
      v_side[0] <= q_side[SQN];
      v_sg[0]   <= q_sg[SQN];
      v_ok[0]   <= q_ok[SQN];
      v_len[0]  <= q_r[SQN][LNW-1:0];
      v_q[0]    <= '0;
      for (int i = 0; i < 3; i++) v_rem[0][i] <= XW'(q_m[SQN][i]) << FB;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int SH = QW - j;
    logic [XW-1:0] dvs;

    assign dvs = XW'(v_len[j-1]) << SH;

    always_ff @(posedge clk) begin
      if (rst) v_vld[j] <= 1'b0;
      else if (en) v_vld[j] <= v_vld[j-1];
      if (en) begin
        v_side[j] <= v_side[j-1];
        v_sg[j]   <= v_sg[j-1];
        v_ok[j]   <= v_ok[j-1];
        v_len[j]  <= v_len[j-1];
        for (int i = 0; i < 3; i++) begin
          if (v_rem[j-1][i] >= dvs) begin
            v_rem[j][i] <= v_rem[j-1][i] - dvs;
            v_q[j][i]   <= v_q[j-1][i] | (QW'(1) << SH);
          end else begin
            v_rem[j][i] <= v_rem[j-1][i];
            v_q[j][i]   <= v_q[j-1][i];
          end
        end
      end
    end
  end

  // sign and zero vector
  logic               o_vld;
  logic [SW-1:0]      o_side;
  logic               o_ok;
  logic [2:0][NW-1:0] o_n;

  always_ff @(posedge clk) begin
    if (rst) o_vld <= 1'b0;
    else if (en) o_vld <= v_vld[QW];
    if (en) begin
      o_side <= v_side[QW];
      o_ok   <= v_ok[QW];
      for (int i = 0; i < 3; i++) begin
        if (!v_ok[QW]) o_n[i] <= '0;
        else if (v_sg[QW][i]) o_n[i] <= NW'(0) - NW'(v_q[QW][i]);
        else o_n[i] <= NW'(v_q[QW][i]);
      end
    end
  end

  assign out_valid = o_vld;
  assign out_n     = o_n;
  assign out_ok    = o_ok;
  assign out_side  = o_side;

endmodule

FILE: hw/rtl/look_at_view_matrix_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// look_at_view_matrix_unit
// Right-handed look-at view matrix rows from eye, aim point and world up.
//
// pose (sink): one request holds eye, aim and sky vectors in signed Q.F.
// rows (source): three results per request, right, up and negated forward,
// each with its translation term; last_row marks the third, degenerate is
// set on all three when forward or right has zero length.
// The first row leaves once the request has passed the request register,
// both normalizers and the cross product and row stages; the other two
// rows follow in order as rows.ready takes them. The datapath is one long
// pipeline: two normalizers, each with a 32 stage square root and a
// FRAC_BITS + 1 stage divider. The pipeline takes a request every cycle
// unless stalled; the result port drains one row a cycle while rows.ready
// is high. The whole pipeline freezes while its last stage is full and the
// serializer cannot load it; pose.ready then drops and nothing is lost or repeated.
// Reset clears every valid bit; the pipeline is empty after reset.
// ----------------------------------------------------------------------------
module look_at_view_matrix_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  lav_pose_if.sink    pose,
  lav_row_if.source   rows
);

  localparam int FB   = FRAC_BITS;
  localparam int DW   = 33;
  localparam int NW   = FB + 2;
  localparam int PW   = NW + 32;
  localparam int CRW  = PW + 1;
  localparam int S1W  = 192;
  localparam int S2W  = 96 + 3 * NW + 1;
  localparam int RFW  = 2 * NW;
  localparam int URW  = RFW + 1;
  localparam int UW   = FB + 3;
  localparam int DTW  = FB + 36;
  localparam int RTW  = DTW - FB;

  function automatic logic signed [RTW-1:0] rnd_tr(input logic signed [DTW-1:0] x);
    logic signed [DTW-1:0] t;
    t = x + (DTW'(1) << (FB - 1));
    return RTW'(t >>> FB);
  endfunction

  function automatic logic signed [UW-1:0] rnd_u(input logic signed [URW-1:0] x);
    logic signed [URW-1:0] t;
    t = x + (URW'(1) << (FB - 1));
    return UW'(t >>> FB);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [RTW-1:0] x);
    if ((&x[RTW-1:31]) || !(|x[RTW-1:31])) return x[31:0];
    else return x[RTW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  logic en;
  logic take;

  // request register and difference
  logic               p0_vld;
  logic [2:0][31:0]   p0_eye;
  logic [2:0][31:0]   p0_sky;
  logic [2:0][DW-1:0] p0_d;

  always_ff @(posedge clk) begin
    if (rst) p0_vld <= 1'b0;
    else if (en) p0_vld <= pose.valid;
    if (en) begin
      p0_eye <= {pose.data.eye_z, pose.data.eye_y, pose.data.eye_x};
      p0_sky <= {pose.data.sky_z, pose.data.sky_y, pose.data.sky_x};
      p0_d[0] <= DW'(pose.data.aim_x) - DW'(pose.data.eye_x);
      p0_d[1] <= DW'(pose.data.aim_y) - DW'(pose.data.eye_y);
      p0_d[2] <= DW'(pose.data.aim_z) - DW'(pose.data.eye_z);
    end
  end

  // forward vector
  logic               f1_vld;
  logic [2:0][NW-1:0] f1_n;
  logic               f1_ok;
  logic [S1W-1:0]     f1_side;
  logic [2:0][31:0]   f1_eye;
  logic [2:0][31:0]   f1_sky;

  lav_unitize #(.IW(DW), .FB(FB), .SW(S1W)) u_fwd (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (p0_vld),
    .in_v      (p0_d),
    .in_side   ({p0_eye, p0_sky}),
    .out_valid (f1_vld),
    .out_n     (f1_n),
    .out_ok    (f1_ok),
    .out_side  (f1_side)
  );

  assign {f1_eye, f1_sky} = f1_side;

  // forward x sky
  logic                  x1_vld;
  logic signed [PW-1:0]  x1_pr [6];
  logic [2:0][31:0]      x1_eye;
  logic [2:0][NW-1:0]    x1_f;
  logic                  x1_ok;

  always_ff @(posedge clk) begin
    if (rst) x1_vld <= 1'b0;
    else if (en) x1_vld <= f1_vld;
    if (en) begin
      x1_pr[0] <= PW'($signed(f1_n[1])) * PW'($signed(f1_sky[2]));
      x1_pr[1] <= PW'($signed(f1_n[2])) * PW'($signed(f1_sky[1]));
      x1_pr[2] <= PW'($signed(f1_n[2])) * PW'($signed(f1_sky[0]));
      x1_pr[3] <= PW'($signed(f1_n[0])) * PW'($signed(f1_sky[2]));
      x1_pr[4] <= PW'($signed(f1_n[0])) * PW'($signed(f1_sky[1]));
      x1_pr[5] <= PW'($signed(f1_n[1])) * PW'($signed(f1_sky[0]));
      x1_eye <= f1_eye;
      x1_f   <= f1_n;
      x1_ok  <= f1_ok;
    end
  end

  logic                x2_vld;
  logic [2:0][CRW-1:0] x2_c;
  logic [2:0][31:0]    x2_eye;
  logic [2:0][NW-1:0]  x2_f;
  logic                x2_ok;

  always_ff @(posedge clk) begin
    if (rst) x2_vld <= 1'b0;
    else if (en) x2_vld <= x1_vld;
    if (en) begin
      x2_c[0] <= CRW'(x1_pr[0]) - CRW'(x1_pr[1]);
      x2_c[1] <= CRW'(x1_pr[2]) - CRW'(x1_pr[3]);
      x2_c[2] <= CRW'(x1_pr[4]) - CRW'(x1_pr[5]);
      x2_eye  <= x1_eye;
      x2_f    <= x1_f;
      x2_ok   <= x1_ok;
    end
  end

  // right vector
  logic               r2_vld;
  logic [2:0][NW-1:0] r2_n;
  logic               r2_ok;
  logic [S2W-1:0]     r2_side;
  logic [2:0][31:0]   r2_eye;
  logic [2:0][NW-1:0] r2_f;
  logic               r2_okf;

  lav_unitize #(.IW(CRW), .FB(FB), .SW(S2W)) u_right (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (x2_vld),
    .in_v      (x2_c),
    .in_side   ({x2_eye, x2_f, x2_ok}),
    .out_valid (r2_vld),
    .out_n     (r2_n),
    .out_ok    (r2_ok),
    .out_side  (r2_side)
  );

  assign {r2_eye, r2_f, r2_okf} = r2_side;

  // up products and translation products
  logic                  y1_vld;
  logic signed [RFW-1:0] y1_uf [6];
  logic signed [DTW-1:0] y1_re [3];
  logic signed [DTW-1:0] y1_fe [3];
  logic [2:0][NW-1:0]    y1_r;
  logic [2:0][NW-1:0]    y1_f;
  logic [2:0][31:0]      y1_eye;
  logic                  y1_deg;

  always_ff @(posedge clk) begin
    if (rst) y1_vld <= 1'b0;
    else if (en) y1_vld <= r2_vld;
    if (en) begin
      y1_uf[0] <= RFW'($signed(r2_n[1])) * RFW'($signed(r2_f[2]));
      y1_uf[1] <= RFW'($signed(r2_n[2])) * RFW'($signed(r2_f[1]));
      y1_uf[2] <= RFW'($signed(r2_n[2])) * RFW'($signed(r2_f[0]));
      y1_uf[3] <= RFW'($signed(r2_n[0])) * RFW'($signed(r2_f[2]));
      y1_uf[4] <= RFW'($signed(r2_n[0])) * RFW'($signed(r2_f[1]));
      y1_uf[5] <= RFW'($signed(r2_n[1])) * RFW'($signed(r2_f[0]));
      for (int i = 0; i < 3; i++) begin
        y1_re[i] <= DTW'($signed(r2_n[i])) * DTW'($signed(r2_eye[i]));
        y1_fe[i] <= DTW'($signed(r2_f[i])) * DTW'($signed(r2_eye[i]));
      end
      y1_r   <= r2_n;
      y1_f   <= r2_f;
      y1_eye <= r2_eye;
      y1_deg <= !(r2_okf && r2_ok);
    end
  end

  logic                  y2_vld;
  logic signed [URW-1:0] y2_ur [3];
  logic signed [DTW-1:0] y2_t0;
  logic signed [DTW-1:0] y2_t2;
  logic [2:0][NW-1:0]    y2_r;
  logic [2:0][NW-1:0]    y2_f;
  logic [2:0][31:0]      y2_eye;
  logic                  y2_deg;

  always_ff @(posedge clk) begin
    if (rst) y2_vld <= 1'b0;
    else if (en) y2_vld <= y1_vld;
    if (en) begin
      y2_ur[0] <= URW'(y1_uf[0]) - URW'(y1_uf[1]);
      y2_ur[1] <= URW'(y1_uf[2]) - URW'(y1_uf[3]);
      y2_ur[2] <= URW'(y1_uf[4]) - URW'(y1_uf[5]);
      y2_t0  <= -(y1_re[0] + y1_re[1] + y1_re[2]);
      y2_t2  <= y1_fe[0] + y1_fe[1] + y1_fe[2];
      y2_r   <= y1_r;
      y2_f   <= y1_f;
      y2_eye <= y1_eye;
      y2_deg <= y1_deg;
    end
  end

  logic                  y3_vld;
  logic signed [UW-1:0]  y3_u [3];
  logic signed [RTW-1:0] y3_t0;
  logic signed [RTW-1:0] y3_t2;
  logic [2:0][NW-1:0]    y3_r;
  logic [2:0][NW-1:0]    y3_f;
  logic [2:0][31:0]      y3_eye;
  logic                  y3_deg;

  always_ff @(posedge clk) begin
    if (rst) y3_vld <= 1'b0;
    else if (en) y3_vld <= y2_vld;
    if (en) begin
      for (int i = 0; i < 3; i++) y3_u[i] <= rnd_u(y2_ur[i]);
      y3_t0  <= rnd_tr(y2_t0);
      y3_t2  <= rnd_tr(y2_t2);
      y3_r   <= y2_r;
      y3_f   <= y2_f;
      y3_eye <= y2_eye;
      y3_deg <= y2_deg;
    end
  end

  logic                  y4_vld;
  logic signed [DTW-1:0] y4_ue [3];
  logic signed [UW-1:0]  y4_u [3];
  logic signed [RTW-1:0] y4_t0;
  logic signed [RTW-1:0] y4_t2;
  logic [2:0][NW-1:0]    y4_r;
  logic [2:0][NW-1:0]    y4_f;
  logic                  y4_deg;

  always_ff @(posedge clk) begin
    if (rst) y4_vld <= 1'b0;
    else if (en) y4_vld <= y3_vld;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        y4_ue[i] <= DTW'(y3_u[i]) * DTW'($signed(y3_eye[i]));
      end
      y4_u   <= y3_u;
      y4_t0  <= y3_t0;
      y4_t2  <= y3_t2;
      y4_r   <= y3_r;
      y4_f   <= y3_f;
      y4_deg <= y3_deg;
    end
  end

  logic                  y5_vld;
  logic signed [DTW-1:0] y5_t1;
  logic signed [UW-1:0]  y5_u [3];
  logic signed [RTW-1:0] y5_t0;
  logic signed [RTW-1:0] y5_t2;
  logic [2:0][NW-1:0]    y5_r;
  logic [2:0][NW-1:0]    y5_f;
  logic                  y5_deg;

  always_ff @(posedge clk) begin
    if (rst) y5_vld <= 1'b0;
    else if (en) y5_vld <= y4_vld;
    if (en) begin
      y5_t1  <= -(y4_ue[0] + y4_ue[1] + y4_ue[2]);
      y5_u   <= y4_u;
      y5_t0  <= y4_t0;
      y5_t2  <= y4_t2;
      y5_r   <= y4_r;
      y5_f   <= y4_f;
      y5_deg <= y4_deg;
    end
  end

  // finished rows
  logic           y6_vld;
  lav_pkg::mrow_t y6_row0;
  lav_pkg::mrow_t y6_row1;
  lav_pkg::mrow_t y6_row2;
  logic           y6_deg;

  always_ff @(posedge clk) begin
    if (rst) y6_vld <= 1'b0;
    else if (en) y6_vld <= y5_vld;
    if (en) begin
      y6_row0.col0 <= 32'($signed(y5_r[0]));
      y6_row0.col1 <= 32'($signed(y5_r[1]));
      y6_row0.col2 <= 32'($signed(y5_r[2]));
      y6_row0.col3 <= sat32(y5_t0);
      y6_row1.col0 <= 32'(y5_u[0]);
      y6_row1.col1 <= 32'(y5_u[1]);
      y6_row1.col2 <= 32'(y5_u[2]);
      y6_row1.col3 <= sat32(rnd_tr(y5_t1));
      y6_row2.col0 <= 32'(-(UW'($signed(y5_f[0]))));
      y6_row2.col1 <= 32'(-(UW'($signed(y5_f[1]))));
      y6_row2.col2 <= 32'(-(UW'($signed(y5_f[2]))));
      y6_row2.col3 <= sat32(y5_t2);
      y6_deg <= y5_deg;
    end
  end

  // row serializer
  logic              s_busy;
  lav_pkg::row_idx_t s_cnt;
  lav_pkg::mrow_t    s_row0;
  lav_pkg::mrow_t    s_row1;
  lav_pkg::mrow_t    s_row2;
  logic              s_deg;
  lav_pkg::mrow_t    s_sel;

  assign take = !s_busy || (rows.ready && s_cnt == lav_pkg::ROW_FWD);
  assign en   = !y6_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_busy <= 1'b0;
      s_cnt  <= lav_pkg::ROW_RIGHT;
    end else if (y6_vld && take) begin
      s_busy <= 1'b1;
      s_cnt  <= lav_pkg::ROW_RIGHT;
    end else if (s_busy && rows.ready) begin
      if (s_cnt == lav_pkg::ROW_FWD) s_busy <= 1'b0;
      else s_cnt <= s_cnt + 2'd1;
    end
    if (y6_vld && take) begin
      s_row0 <= y6_row0;
      s_row1 <= y6_row1;
      s_row2 <= y6_row2;
      s_deg  <= y6_deg;
    end
  end

  always_comb begin
    unique case (s_cnt)
      lav_pkg::ROW_RIGHT: s_sel = s_row0;
      lav_pkg::ROW_UP:    s_sel = s_row1;
      default:            s_sel = s_row2;
    endcase
  end

  assign pose.ready            = en;
  assign rows.valid            = s_busy;
  assign rows.data.row_index   = s_cnt;
  assign rows.data.col0        = s_sel.col0;
  assign rows.data.col1        = s_sel.col1;
  assign rows.data.col2        = s_sel.col2;
  assign rows.data.col3        = s_sel.col3;
  assign rows.data.last_row    = (s_cnt == lav_pkg::ROW_FWD);
  assign rows.data.degenerate  = s_deg;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (y6_vld && !en) |=> (y6_vld && $stable(y6_row2) && $stable(y6_row0)))
    else $error("final stage changed while stalled");

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (rows.valid && rows.ready && !rows.data.last_row) |=>
      (rows.valid && rows.data.row_index == $past(rows.data.row_index) + 2'd1))
    else $error("row sequence broken");

  a_load_first: assert property (@(posedge clk) disable iff (rst)
    (y6_vld && en) |=> (rows.valid && rows.data.row_index == lav_pkg::ROW_RIGHT))
    else $error("loaded request does not start at the right row");

endmodule

FILE: sim/lav_row_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lav_row_checker
// Watches the pose and row channels of the look-at unit. Every accepted pose
// request is turned into the three expected view matrix rows by an
// independent fixed-point model; every accepted row is compared field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module lav_row_checker #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  lav_pose_if  pose,
  lav_row_if   rows,
  output int   fail_count,
  output int   rows_pending,
  output int   rows_checked
);

  typedef longint vec3_t [3];

  lav_pkg::row_t view_rows_q [$];

  function automatic longint unsigned isqrt_u64(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic bit normalize3(input vec3_t v, output vec3_t n);
    longint unsigned m [3];
    longint unsigned top = 0;
    longint unsigned sum = 0;
    longint unsigned len;
    longint unsigned q;
    int p = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 3; i++) n[i] = 0;
      return 1'b0;
    end
    while (p < 63 && (top >> (p + 1)) != 0) p++;
    for (int i = 0; i < 3; i++) begin
      if (p > 29) m[i] = m[i] >> (p - 29);
      else m[i] = m[i] << (29 - p);
      sum += m[i] * m[i];
    end
    len = isqrt_u64(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FRAC_BITS) / len;
      n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  // rounds half up, arithmetic shift floors
  function automatic longint round_frac(longint x);
    return (x + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic logic signed [31:0] sat32(longint x);
    if (x > 64'sd2147483647) return 32'sh7fff_ffff;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic longint dot3(vec3_t a, vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  task automatic predict_view_rows(lav_pkg::pose_t p);
    vec3_t eye, dir, sky, fwd, crs, rgt, upv, neg_f;
    bit ok_f, ok_r;
    lav_pkg::row_t r;
    eye = '{longint'(p.eye_x), longint'(p.eye_y), longint'(p.eye_z)};
    sky = '{longint'(p.sky_x), longint'(p.sky_y), longint'(p.sky_z)};
    dir = '{longint'(p.aim_x) - eye[0], longint'(p.aim_y) - eye[1],
            longint'(p.aim_z) - eye[2]};
    ok_f = normalize3(dir, fwd);
    crs[0] = fwd[1] * sky[2] - fwd[2] * sky[1];
    crs[1] = fwd[2] * sky[0] - fwd[0] * sky[2];
    crs[2] = fwd[0] * sky[1] - fwd[1] * sky[0];
    ok_r = normalize3(crs, rgt);
    upv[0] = round_frac(rgt[1] * fwd[2] - rgt[2] * fwd[1]);
    upv[1] = round_frac(rgt[2] * fwd[0] - rgt[0] * fwd[2]);
    upv[2] = round_frac(rgt[0] * fwd[1] - rgt[1] * fwd[0]);
    for (int i = 0; i < 3; i++) neg_f[i] = -fwd[i];

    r.last_row   = 1'b0;
    r.degenerate = !(ok_f && ok_r);
    r.row_index  = lav_pkg::ROW_RIGHT;
    r.col0 = rgt[0][31:0];
    r.col1 = rgt[1][31:0];
    r.col2 = rgt[2][31:0];
    r.col3 = sat32(round_frac(-dot3(rgt, eye)));
    view_rows_q.push_back(r);
    r.row_index = lav_pkg::ROW_UP;
    r.col0 = upv[0][31:0];
    r.col1 = upv[1][31:0];
    r.col2 = upv[2][31:0];
    r.col3 = sat32(round_frac(-dot3(upv, eye)));
    view_rows_q.push_back(r);
    r.row_index = lav_pkg::ROW_FWD;
    r.last_row  = 1'b1;
    r.col0 = neg_f[0][31:0];
    r.col1 = neg_f[1][31:0];
    r.col2 = neg_f[2][31:0];
    r.col3 = sat32(round_frac(dot3(fwd, eye)));
    view_rows_q.push_back(r);
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  initial begin
    fail_count   = 0;
    rows_checked = 0;
  end

  assign rows_pending = view_rows_q.size();

  always @(posedge clk) begin
    lav_pkg::row_t want;
    if (!rst) begin
      if (pose.valid && pose.ready) predict_view_rows(pose.data);
      if (rows.valid && rows.ready) begin
        if (view_rows_q.size() == 0) begin
          $display("%0t unexpected row: expected none actual %h", $time, rows.data);
          fail_count++;
        end else begin
          want = view_rows_q.pop_front();
          check_field("row_index", want.row_index, rows.data.row_index);
          check_field("col0", want.col0, rows.data.col0);
          check_field("col1", want.col1, rows.data.col1);
          check_field("col2", want.col2, rows.data.col2);
          check_field("col3", want.col3, rows.data.col3);
          check_field("last_row", want.last_row, rows.data.last_row);
          check_field("degenerate", want.degenerate, rows.data.degenerate);
          rows_checked++;
        end
      end
    end
  end

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the look-at view matrix unit with directed poses (extremes, eye on
// the aim point, zero and parallel sky, saturating translations) and then
// random poses, with random gaps on both channels and one long row stall.
// ----------------------------------------------------------------------------
module tb;

  localparam int FRAC_BITS  = 16;
  localparam int LATENCY    = 2 * FRAC_BITS + 90;
  localparam int N_RANDOM   = 90;
  localparam int HOLD_LEN   = 400;
  localparam int CYC_LIMIT  = 200000;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int IMAX       = 32'h7fff_ffff;
  localparam int IMIN       = 32'h8000_0000;

  logic clk;
  logic rst;
  int   cyc = 0;
  int   fail_count, rows_pending, rows_checked;
  int   n_sent;
  bit   hold_req;
  bit   calm;

  lav_pose_if pose_ch ();
  lav_row_if  row_ch ();

  look_at_view_matrix_unit #(.FRAC_BITS(FRAC_BITS)) dut (
    .clk  (clk),
    .rst  (rst),
    .pose (pose_ch),
    .rows (row_ch)
  );

  lav_row_checker #(.FRAC_BITS(FRAC_BITS)) chk (
    .clk          (clk),
    .rst          (rst),
    .pose         (pose_ch),
    .rows         (row_ch),
    .fail_count   (fail_count),
    .rows_pending (rows_pending),
    .rows_checked (rows_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("timeout at cycle %0d", cyc);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // row sink: random back-pressure, one long hold-off
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    row_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        row_ch.ready <= 1'b0;
      end else begin
        row_ch.ready <= calm || ($urandom_range(99) >= 21);
      end
    end
  end

  function automatic lav_pkg::pose_t mk_pose(int ex, int ey, int ez, int ax, int ay, int az,
                                             int sx, int sy, int sz);
    lav_pkg::pose_t p;
    p = '{ex, ey, ez, ax, ay, az, sx, sy, sz};
    return p;
  endfunction

  function automatic int small_val();
    return int'($urandom_range(0, 2097152)) - 1048576;
  endfunction

  function automatic lav_pkg::pose_t rand_pose();
    lav_pkg::pose_t p;
    int mode;
    int k;
    mode = $urandom_range(99);
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom};
    if (mode < 75) begin
      p.eye_x = small_val(); p.eye_y = small_val(); p.eye_z = small_val();
      p.aim_x = small_val(); p.aim_y = small_val(); p.aim_z = small_val();
      p.sky_x = small_val(); p.sky_y = small_val(); p.sky_z = small_val();
    end
    if (mode >= 50 && mode < 58) begin
      p.aim_x = p.eye_x; p.aim_y = p.eye_y; p.aim_z = p.eye_z;
    end else if (mode >= 58 && mode < 68) begin
      k = $urandom_range(1) ? 1 : -1;
      p.sky_x = k * (p.aim_x - p.eye_x);
      p.sky_y = k * (p.aim_y - p.eye_y);
      p.sky_z = k * (p.aim_z - p.eye_z);
    end else if (mode >= 68 && mode < 75) begin
      p.sky_x = 0; p.sky_y = 0; p.sky_z = 0;
    end
    return p;
  endfunction

  task automatic send_pose(lav_pkg::pose_t p, bit gaps);
    if (gaps) begin
      while ($urandom_range(99) < 21) begin
        pose_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pose_ch.valid <= 1'b1;
    pose_ch.data  <= p;
    do @(posedge clk); while (!pose_ch.ready);
    n_sent++;
  endtask

  initial begin
    lav_pkg::pose_t directed [$];
    n_sent = 0;
    hold_req = 0;
    calm = 0;
    rst = 1'b1;
    pose_ch.valid <= 1'b0;
    pose_ch.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed.push_back(mk_pose(0, 0, 5 * ONE, 0, 0, 0, 0, ONE, 0));
    directed.push_back(mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_pose(IMAX, IMAX, IMAX, IMAX, IMAX, IMAX, 0, ONE, 0));
    directed.push_back(mk_pose(IMIN, IMIN, IMIN, IMAX, IMAX, IMAX, 0, ONE, 0));
    directed.push_back(mk_pose(IMAX, IMAX, IMAX, IMIN, IMIN, IMIN, IMAX, IMIN, 0));
    directed.push_back(mk_pose(IMIN, IMAX, IMIN, IMAX, IMIN, IMAX, IMIN, IMIN, IMIN));
    directed.push_back(mk_pose(0, 0, 0, ONE, 0, 0, 0, 0, 0));
    directed.push_back(mk_pose(0, 0, 0, 0, ONE, 0, 0, 3 * ONE, 0));
    directed.push_back(mk_pose(0, 0, 0, 0, ONE, 0, 0, -ONE, 0));
    directed.push_back(mk_pose(ONE, 2 * ONE, 3 * ONE, 2 * ONE, 4 * ONE, 6 * ONE,
                               ONE, 2 * ONE, 3 * ONE));
    directed.push_back(mk_pose(IMAX, IMIN, IMAX, 0, 0, 0, 0, ONE, 0));
    directed.push_back(mk_pose(IMIN, IMIN, IMIN, 0, 0, 0, ONE, 0, 0));
    directed.push_back(mk_pose(0, 0, 0, 1, 0, 0, 0, 0, 1));
    directed.push_back(mk_pose(0, 0, 0, 1, 1, 1, 0, 1, 0));
    directed.push_back(mk_pose(-1, -1, -1, 0, 0, 0, IMAX, IMAX, IMAX));
    directed.push_back(mk_pose(123, -456, 789, -1000, 2000, -3000, IMIN, IMAX, 1));
    directed.push_back(mk_pose(IMAX, 0, 0, IMAX, 0, 0, 0, ONE, 0));
    directed.push_back(mk_pose(0, IMIN, 0, 0, IMAX, 0, IMIN, 0, IMAX));
    directed.push_back(mk_pose(-1, 0, 0, 0, 0, 0, -1, -1, -1));
    directed.push_back(mk_pose(5 * ONE, 5 * ONE, 5 * ONE, 0, 0, 0, 0, 0, ONE));
    foreach (directed[i]) send_pose(directed[i], 1'b1);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 10) hold_req = 1;
      calm = (i >= 60 && i < 85);
      send_pose(rand_pose(), !calm);
    end
    pose_ch.valid <= 1'b0;
    calm = 0;

    while (rows_pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("sent %0d poses (%0d directed), checked %0d rows incl. degenerate,",
             n_sent, directed.size(), rows_checked);
    $display("parallel-sky and saturating cases, with a %0d cycle row stall", HOLD_LEN);
    if (fail_count == 0 && rows_pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/lav_pkg.sv
hw/rtl/lav_if.sv
hw/rtl/lav_unitize.sv
hw/rtl/look_at_view_matrix_unit.sv
sim/lav_row_checker.sv
sim/tb.sv
